// ===== design/srrf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srrf_pkg - sorted row range finder shared types
// Beat formats of the element and result channels, value width and the
// register map of the configuration port.
// ----------------------------------------------------------------------------
package srrf_pkg;

	localparam int VALUE_W    = 16;
	localparam int TAG_W      = 8;
	localparam int IDX_W      = 4;
	localparam int TOTAL_W    = 16;
	localparam int RESULT_CAP = 16;
	localparam int PADDR_W    = 3;

	localparam logic [PADDR_W-1:0] ADDR_RANGE_LOW  = 3'h0;
	localparam logic [PADDR_W-1:0] ADDR_RANGE_HIGH = 3'h4;

	localparam logic signed [VALUE_W-1:0] RANGE_LOW_RST  = 16'sd0;
	localparam logic signed [VALUE_W-1:0] RANGE_HIGH_RST = 16'sd5;

	typedef struct packed {
		logic signed [VALUE_W-1:0] element_value;
		logic [TAG_W-1:0]          row_tag;
		logic                      last_element;
	} elem_beat_t;

	typedef struct packed {
		logic [TAG_W-1:0]          result_row;
		logic [IDX_W-1:0]          found_index;
		logic signed [VALUE_W-1:0] found_value;
		logic                      none_found;
		logic [TOTAL_W-1:0]        total_found;
		logic                      last_result;
	} res_beat_t;

endpackage

// ===== design/srrf_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srrf_ram - generic simple dual port ram
// One write port and one read port, read data registered and held while
// no read is issued.
// ----------------------------------------------------------------------------
module srrf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== design/sorted_row_range_finder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_row_range_finder_core - range query over one sorted row
// Element beats (elem_valid/elem_ready) load an ascending row into a small
// ram, one beat per cycle while idle, nothing is returned for them. The beat with
// last_element set closes the row: a lower-bound binary search for the first
// value at or above range_low runs over the ram, the hit is grown left and
// right over neighbours inside [range_low, range_high], and one result beat
// is sent per element found (at most 16), else a single none-found beat.
// All steps share the one ram read port and one compare: each search step,
// growth step and result is a ram read state followed by a state that uses
// the read data, and the search takes at most ceil(log2(n+1)) steps. The next
// element beat is taken only after the last result beat is placed; elem_ready
// is low throughout. Result beats sit in an output register; a stall on
// res_ready holds the sequencer until the register frees; the last result of
// a row may still wait there while loading resumes. Range registers sit on
// the APB port at 0x0 and 0x4; the user must write them only while idle, the
// block does not enforce it. Reset (arst_n low) empties the row, clears the
// found count and sets the range to [0, 5]; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_row_range_finder_core
	import srrf_pkg::*;
#(
	parameter int ROW_DEPTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 elem_valid,
	output logic                 elem_ready,
	input  elem_beat_t           elem,
	output logic                 res_valid,
	input  logic                 res_ready,
	output res_beat_t            res,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	localparam int AW = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;
	localparam int CW = $clog2(ROW_DEPTH + 1);
	localparam int KW = $clog2(RESULT_CAP);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_BS   = 4'd1;
	localparam logic [3:0] ST_BSC  = 4'd2;
	localparam logic [3:0] ST_FIX  = 4'd3;
	localparam logic [3:0] ST_CHK  = 4'd4;
	localparam logic [3:0] ST_L    = 4'd5;
	localparam logic [3:0] ST_LC   = 4'd6;
	localparam logic [3:0] ST_R    = 4'd7;
	localparam logic [3:0] ST_RC   = 4'd8;
	localparam logic [3:0] ST_EM   = 4'd9;
	localparam logic [3:0] ST_EO   = 4'd10;

	logic [3:0]                state_q;
	logic [CW-1:0]             fill_q;
	logic [CW-1:0]             n_q;
	logic [TAG_W-1:0]          tag_q;
	logic signed [CW:0]        lo_q;
	logic signed [CW:0]        hi_q;
	logic signed [CW:0]        mid;
	logic signed [CW:0]        mid_q;
	logic [AW-1:0]             res_idx_q;
	logic                      res_hit_q;
	logic [AW-1:0]             left_q;
	logic [AW-1:0]             right_q;
	logic [AW-1:0]             k_q;
	logic [KW-1:0]             cnt_q;
	logic [TOTAL_W-1:0]        found_q;
	logic [TOTAL_W-1:0]        found_next;
	logic signed [VALUE_W-1:0] range_low_q;
	logic signed [VALUE_W-1:0] range_high_q;
	logic                      res_valid_q;
	res_beat_t                 res_q;

	logic                      elem_fire;
	logic                      store_en;
	logic [CW-1:0]             fill_inc;
	logic [CW-1:0]             n_m1;
	logic                      rd_en;
	logic [AW-1:0]             rd_addr;
	logic [VALUE_W-1:0]        rd_data;
	logic signed [VALUE_W-1:0] rd_val;
	logic                      rd_in_range;
	logic                      slot_free;
	logic                      last_hit;
	logic                      cfg_wr;

	// ---------------------------------------------------------------- apb
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q  <= RANGE_LOW_RST;
			range_high_q <= RANGE_HIGH_RST;
		end else if (cfg_wr) begin
			case (paddr)
				ADDR_RANGE_LOW:  range_low_q  <= pwdata[VALUE_W-1:0];
				ADDR_RANGE_HIGH: range_high_q <= pwdata[VALUE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr)
			ADDR_RANGE_LOW:  prdata = {{(32-VALUE_W){1'b0}}, range_low_q};
			ADDR_RANGE_HIGH: prdata = {{(32-VALUE_W){1'b0}}, range_high_q};
			default:         prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------- row store
	assign elem_ready = (state_q == ST_IDLE);
	assign elem_fire  = elem_valid && elem_ready;
	assign store_en   = elem_fire && (fill_q < CW'(ROW_DEPTH));
	assign fill_inc   = fill_q + CW'(1);
	assign n_m1       = n_q - CW'(1);
	assign mid        = lo_q + ((hi_q - lo_q) >>> 1);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = k_q;
		case (state_q)
			ST_BS: begin
				rd_en   = (lo_q <= hi_q);
				rd_addr = mid[AW-1:0];
			end
			ST_FIX: begin
				rd_en   = 1'b1;
				rd_addr = res_hit_q ? res_idx_q : n_m1[AW-1:0];
			end
			ST_L: begin
				rd_en   = (left_q != '0);
				rd_addr = left_q - AW'(1);
			end
			ST_R: begin
				rd_en   = (CW'(right_q) < n_m1);
				rd_addr = right_q + AW'(1);
			end
			ST_EM: begin
				rd_en   = 1'b1;
				rd_addr = k_q;
			end
			default: ;
		endcase
	end

	srrf_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (ROW_DEPTH)
	) u_row_ram (
		.clk     (clk),
		.wr_en   (store_en),
		.wr_addr (fill_q[AW-1:0]),
		.wr_data (elem.element_value),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign rd_val      = $signed(rd_data);
	assign rd_in_range = (rd_val >= range_low_q) && (rd_val <= range_high_q);
	assign slot_free   = !res_valid_q || res_ready;
	assign last_hit    = (k_q == right_q) || (cnt_q == KW'(RESULT_CAP - 1));
	assign found_next  = (found_q != '1) ? found_q + TOTAL_W'(1) : found_q;

	// ---------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			found_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (elem_fire && elem.last_element) begin
						n_q       <= store_en ? fill_inc : fill_q;
						fill_q    <= '0;
						tag_q     <= elem.row_tag;
						lo_q      <= '0;
						hi_q      <= $signed({1'b0, (store_en ? fill_inc : fill_q)})
							- (CW+1)'(1);
						res_hit_q <= 1'b0;
						state_q   <= ST_BS;
					end else if (store_en) begin
						fill_q <= fill_inc;
					end
				end
				ST_BS: begin
					mid_q   <= mid;
					state_q <= (lo_q <= hi_q) ? ST_BSC : ST_FIX;
				end
				ST_BSC: begin
					if (rd_val >= range_low_q) begin
						res_idx_q <= mid_q[AW-1:0];
						res_hit_q <= 1'b1;
						hi_q      <= mid_q - (CW+1)'(1);
					end else begin
						lo_q <= mid_q + (CW+1)'(1);
					end
					state_q <= ST_BS;
				end
				ST_FIX: begin
					left_q  <= res_hit_q ? res_idx_q : n_m1[AW-1:0];
					right_q <= res_hit_q ? res_idx_q : n_m1[AW-1:0];
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (rd_in_range) begin
						state_q <= ST_L;
					end else if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_L: begin
					state_q <= (left_q != '0) ? ST_LC : ST_R;
				end
				ST_LC: begin
					if (rd_in_range) begin
						left_q  <= left_q - AW'(1);
						state_q <= ST_L;
					end else begin
						state_q <= ST_R;
					end
				end
				ST_R: begin
					k_q     <= left_q;
					cnt_q   <= '0;
					state_q <= (CW'(right_q) < n_m1) ? ST_RC : ST_EM;
				end
				ST_RC: begin
					if (rd_in_range) begin
						right_q <= right_q + AW'(1);
						state_q <= ST_R;
					end else begin
						state_q <= ST_EM;
					end
				end
				ST_EM: begin
					state_q <= ST_EO;
				end
				ST_EO: begin
					if (slot_free) begin
						found_q <= found_next;
						k_q     <= k_q + AW'(1);
						cnt_q   <= cnt_q + KW'(1);
						state_q <= last_hit ? ST_IDLE : ST_EM;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---------------------------------------------------------------- result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if ((state_q == ST_CHK && !rd_in_range && slot_free) ||
			(state_q == ST_EO && slot_free)) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CHK && !rd_in_range && slot_free) begin
			res_q.result_row  <= tag_q;
			res_q.found_index <= '0;
			res_q.found_value <= '0;
			res_q.none_found  <= 1'b1;
			res_q.total_found <= found_q;
			res_q.last_result <= 1'b1;
		end else if (state_q == ST_EO && slot_free) begin
			res_q.result_row  <= tag_q;
			res_q.found_index <= IDX_W'(k_q);
			res_q.found_value <= rd_val;
			res_q.none_found  <= 1'b0;
			res_q.total_found <= found_next;
			res_q.last_result <= last_hit;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// ---------------------------------------------------------------- checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(ROW_DEPTH))
		else $error("row fill beyond depth");

	a_emit_window: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EO |-> (k_q >= left_q) && (k_q <= right_q))
		else $error("emitted index outside grown range");

	a_none_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.none_found |-> res_q.last_result)
		else $error("none-found beat not last");

	a_found_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_q.none_found |-> res_q.total_found != '0)
		else $error("found beat with zero total");

	a_count_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> found_q >= $past(found_q))
		else $error("found count went backwards");

endmodule
